FILE: src/vrlm_pkg.sv
package vrlm_pkg;

  // Field and state widths.
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned GRP_W     = 7;
  localparam int unsigned ACC_W     = 21;
  localparam int unsigned RUN_W     = 28;
  localparam int unsigned NX_W      = 29;
  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned ROW_W     = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CONT_POS  = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FILL = 2'd1;

  // Result kinds.
  localparam logic KIND_RECT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_NOT_MULT = 3'd3,
    ST_ROW_OVF  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DIV,
    S_CHECK,
    S_EMIT,
    S_TERM
  } state_t;

  // Which of the up to three rectangles of a set run is being sent.
  localparam logic [1:0] RECT_HEAD_ROW = 2'd0;
  localparam logic [1:0] RECT_BODY     = 2'd1;
  localparam logic [1:0] RECT_TAIL_ROW = 2'd2;

endpackage

FILE: src/vrlm_div.sv
// Restoring divider, one quotient bit per cycle.
module vrlm_div #(
  parameter int unsigned DVD_W = vrlm_pkg::NX_W,
  parameter int unsigned DVS_W = vrlm_pkg::WIDTH_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             borrow;

  // Shared trial subtraction.
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign borrow  = diff[DVS_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // The dividend register fills with quotient bits from the right.
      rem_nxt = borrow ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], ~borrow};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

FILE: src/varint_run_length_mask_decoder.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// in_      | in_valid / in_ready   | in_data_byte
// out_     | out_valid / out_ready | out_kind, out_rect_*, out_mask_height,
//          |                       | out_status, out_last
// cfg_     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A continuation byte or an ignored byte is taken in the idle state. A run that
// stays in its row passes through the run state, and through the send state when
// it sends its rectangle. A run that wraps a row goes through the run state, the
// serial divider (one quotient bit a cycle), the check state and then the send
// state once per rectangle sent. A terminator passes through the terminator state.
// Reset is synchronous and active low; it clears the mask state and loads the
// register defaults (width 1, first run clear). A stalled output holds the
// sequencer in its send state; the output register lets the next request in
// while the last result of the previous one still waits.
module varint_run_length_mask_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [vrlm_pkg::DATA_W-1:0]        in_data_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_kind,
  output logic [vrlm_pkg::WIDTH_W-1:0]       out_rect_x,
  output logic [vrlm_pkg::ROW_W-1:0]         out_rect_y,
  output logic [vrlm_pkg::WIDTH_W-1:0]       out_rect_width,
  output logic [vrlm_pkg::ROW_W-1:0]         out_rect_height,
  output logic [vrlm_pkg::ROW_W-1:0]         out_mask_height,
  output logic [vrlm_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vrlm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vrlm_pkg::WIDTH_W-1:0]       cfg_data
);

  localparam int unsigned ACC_W   = vrlm_pkg::ACC_W;
  localparam int unsigned RUN_W   = vrlm_pkg::RUN_W;
  localparam int unsigned NX_W    = vrlm_pkg::NX_W;
  localparam int unsigned WIDTH_W = vrlm_pkg::WIDTH_W;
  localparam int unsigned ROW_W   = vrlm_pkg::ROW_W;
  localparam int unsigned GRP_W   = vrlm_pkg::GRP_W;

  vrlm_pkg::state_t  state_r, state_nxt;
  vrlm_pkg::status_t err_r, err_nxt;
  vrlm_pkg::status_t term_st_r, term_st_nxt;

  logic [WIDTH_W-1:0] mask_width_r, mask_width_nxt;
  logic               first_fill_r, first_fill_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [1:0]         gc_r, gc_nxt;
  logic [WIDTH_W-1:0] column_r, column_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               fill_r, fill_nxt;

  // Working registers of the run in flight.
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic [NX_W-1:0]    nx_r, nx_nxt;
  logic [WIDTH_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]   rbase_r, rbase_nxt;
  logic [WIDTH_W-1:0] r0w_r, r0w_nxt;
  logic [NX_W-1:0]    h_r, h_nxt;
  logic [WIDTH_W-1:0] x_r, x_nxt;
  logic               run_fill_r, run_fill_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [ROW_W-1:0]   term_h_r, term_h_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [WIDTH_W-1:0] out_x_r, out_x_nxt;
  logic [ROW_W-1:0]   out_y_r, out_y_nxt;
  logic [WIDTH_W-1:0] out_w_r, out_w_nxt;
  logic [ROW_W-1:0]   out_h_r, out_h_nxt;
  logic [ROW_W-1:0]   out_mh_r, out_mh_nxt;
  logic [vrlm_pkg::STATUS_W-1:0] out_st_r, out_st_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic               slot_free;
  logic [WIDTH_W-1:0] w_eff;
  logic [GRP_W-1:0]   grp;
  logic               cont;
  logic [RUN_W-1:0]   run_asm;
  logic [WIDTH_W-1:0] col_eff;
  logic               short_run;
  logic [NX_W-1:0]    rest;
  logic               div_start;
  logic               div_done;
  logic [NX_W-1:0]    div_q;
  logic [WIDTH_W-1:0] div_r;
  logic [ROW_W:0]     r_sum;
  logic               row_ovf;
  logic [1:0]         idx_after;
  logic               more_rects;
  logic               term_byte;
  logic               run_done_byte;

  assign in_ready  = (state_r == vrlm_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign w_eff     = (mask_width_r == '0) ? WIDTH_W'(1) : mask_width_r;
  assign grp       = in_data_byte[GRP_W-1:0];
  assign cont      = in_data_byte[vrlm_pkg::CONT_POS];
  assign term_byte = (in_data_byte == '0);

  // A non-zero byte without the continuation bit closes a run unless an error is held.
  assign run_done_byte = !term_byte && (err_r == vrlm_pkg::ST_OK) && !cont;

  // Place the new 7-bit group above the groups gathered so far.
  always_comb begin
    case (gc_r)
      2'd0:    run_asm = {{(RUN_W-ACC_W){1'b0}}, acc_r} | RUN_W'(grp);
      2'd1:    run_asm = {{(RUN_W-ACC_W){1'b0}}, acc_r} | (RUN_W'(grp) << GRP_W);
      2'd2:    run_asm = {{(RUN_W-ACC_W){1'b0}}, acc_r} | (RUN_W'(grp) << (2*GRP_W));
      default: run_asm = {{(RUN_W-ACC_W){1'b0}}, acc_r} | (RUN_W'(grp) << (3*GRP_W));
    endcase
  end

  // A column left beyond a narrowed width restarts at the row's left edge.
  assign col_eff = (column_r < w_eff) ? column_r : '0;

  // Run evaluation: stays in the row, or wraps and needs the divider.
  assign short_run = (nx_r < NX_W'(w_eff));
  assign rest      = nx_r - NX_W'(w_eff);
  assign div_start = (state_r == vrlm_pkg::S_RUN) && !short_run;

  vrlm_div #(
    .DVD_W (NX_W),
    .DVS_W (WIDTH_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rest),
    .divisor   (w_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Row after the run, with one spare bit to catch overflow.
  assign r_sum   = {1'b0, rbase_r} + (ROW_W+1)'(h_r) + (ROW_W+1)'(1);
  assign row_ovf = r_sum[ROW_W];

  // Next rectangle after the one being sent.
  always_comb begin
    idx_after  = vrlm_pkg::RECT_TAIL_ROW;
    more_rects = 1'b0;
    case (idx_r)
      vrlm_pkg::RECT_HEAD_ROW: begin
        if (h_r != '0) begin
          idx_after  = vrlm_pkg::RECT_BODY;
          more_rects = 1'b1;
        end else if (x_r != '0) begin
          idx_after  = vrlm_pkg::RECT_TAIL_ROW;
          more_rects = 1'b1;
        end
      end
      vrlm_pkg::RECT_BODY: begin
        more_rects = (x_r != '0);
      end
      default: more_rects = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vrlm_pkg::S_IDLE: begin
        if (in_acc) begin
          if (term_byte) begin
            state_nxt = vrlm_pkg::S_TERM;
          end else if (run_done_byte) begin
            state_nxt = vrlm_pkg::S_RUN;
          end
        end
      end
      vrlm_pkg::S_RUN: begin
        if (!short_run) begin
          state_nxt = vrlm_pkg::S_DIV;
        end else if (run_fill_r && (run_r != '0)) begin
          state_nxt = vrlm_pkg::S_EMIT;
        end else begin
          state_nxt = vrlm_pkg::S_IDLE;
        end
      end
      vrlm_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = vrlm_pkg::S_CHECK;
        end
      end
      vrlm_pkg::S_CHECK: begin
        if (!row_ovf && run_fill_r) begin
          state_nxt = vrlm_pkg::S_EMIT;
        end else begin
          state_nxt = vrlm_pkg::S_IDLE;
        end
      end
      vrlm_pkg::S_EMIT: begin
        if (slot_free && !more_rects) begin
          state_nxt = vrlm_pkg::S_IDLE;
        end
      end
      vrlm_pkg::S_TERM: begin
        if (slot_free) begin
          state_nxt = vrlm_pkg::S_IDLE;
        end
      end
      default: state_nxt = vrlm_pkg::S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    mask_width_nxt = mask_width_r;
    first_fill_nxt = first_fill_r;
    acc_nxt        = acc_r;
    gc_nxt         = gc_r;
    column_nxt     = column_r;
    row_nxt        = row_r;
    fill_nxt       = fill_r;
    err_nxt        = err_r;
    run_nxt        = run_r;
    nx_nxt         = nx_r;
    col_nxt        = col_r;
    rbase_nxt      = rbase_r;
    r0w_nxt        = r0w_r;
    h_nxt          = h_r;
    x_nxt          = x_r;
    run_fill_nxt   = run_fill_r;
    idx_nxt        = idx_r;
    term_st_nxt    = term_st_r;
    term_h_nxt     = term_h_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_w_nxt      = out_w_r;
    out_h_nxt      = out_h_r;
    out_mh_nxt     = out_mh_r;
    out_st_nxt     = out_st_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      vrlm_pkg::S_IDLE: begin
        if (in_acc) begin
          if (term_byte) begin
            // End of mask: settle the status, then start a fresh mask.
            term_st_nxt = err_r;
            if (err_r == vrlm_pkg::ST_OK && gc_r != '0) begin
              term_st_nxt = vrlm_pkg::ST_TRUNC;
            end else if (err_r == vrlm_pkg::ST_OK && column_r != '0) begin
              term_st_nxt = vrlm_pkg::ST_NOT_MULT;
            end
            term_h_nxt = row_r;
            acc_nxt    = '0;
            gc_nxt     = '0;
            column_nxt = '0;
            row_nxt    = '0;
            fill_nxt   = first_fill_r;
            err_nxt    = vrlm_pkg::ST_OK;
          end else if (err_r == vrlm_pkg::ST_OK) begin
            if (cont && gc_r == 2'd3) begin
              err_nxt = vrlm_pkg::ST_TOO_BIG;
              acc_nxt = '0;
              gc_nxt  = '0;
            end else if (cont) begin
              acc_nxt = run_asm[ACC_W-1:0];
              gc_nxt  = gc_r + 2'd1;
            end else begin
              run_nxt      = run_asm;
              col_nxt      = col_eff;
              nx_nxt       = NX_W'(col_eff) + NX_W'(run_asm);
              run_fill_nxt = fill_r;
              acc_nxt      = '0;
              gc_nxt       = '0;
            end
          end
        end
      end
      vrlm_pkg::S_RUN: begin
        rbase_nxt = row_r;
        idx_nxt   = vrlm_pkg::RECT_HEAD_ROW;
        if (short_run) begin
          r0w_nxt    = run_r[WIDTH_W-1:0];
          h_nxt      = '0;
          x_nxt      = '0;
          column_nxt = nx_r[WIDTH_W-1:0];
          fill_nxt   = ~fill_r;
        end else begin
          r0w_nxt = w_eff - col_r;
        end
      end
      vrlm_pkg::S_DIV: begin
        if (div_done) begin
          h_nxt = div_q;
          x_nxt = div_r;
        end
      end
      vrlm_pkg::S_CHECK: begin
        if (row_ovf) begin
          err_nxt = vrlm_pkg::ST_ROW_OVF;
        end else begin
          row_nxt    = r_sum[ROW_W-1:0];
          column_nxt = x_r;
          fill_nxt   = ~fill_r;
        end
      end
      vrlm_pkg::S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = vrlm_pkg::KIND_RECT;
          out_mh_nxt    = '0;
          out_st_nxt    = vrlm_pkg::ST_OK;
          out_last_nxt  = !more_rects;
          idx_nxt       = idx_after;
          case (idx_r)
            vrlm_pkg::RECT_HEAD_ROW: begin
              out_x_nxt = col_r;
              out_y_nxt = rbase_r;
              out_w_nxt = r0w_r;
              out_h_nxt = ROW_W'(1);
            end
            vrlm_pkg::RECT_BODY: begin
              out_x_nxt = '0;
              out_y_nxt = rbase_r + ROW_W'(1);
              out_w_nxt = w_eff;
              out_h_nxt = ROW_W'(h_r);
            end
            default: begin
              // The row register already holds the last row of the run.
              out_x_nxt = '0;
              out_y_nxt = row_r;
              out_w_nxt = x_r;
              out_h_nxt = ROW_W'(1);
            end
          endcase
        end
      end
      vrlm_pkg::S_TERM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = vrlm_pkg::KIND_END;
          out_x_nxt     = '0;
          out_y_nxt     = '0;
          out_w_nxt     = '0;
          out_h_nxt     = '0;
          out_mh_nxt    = (term_st_r == vrlm_pkg::ST_OK) ? term_h_r : '0;
          out_st_nxt    = term_st_r;
          out_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase

    // Register writes; a polarity write also reloads the current polarity.
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vrlm_pkg::CFG_MASK_WIDTH: mask_width_nxt = cfg_data;
        vrlm_pkg::CFG_FIRST_FILL: begin
          first_fill_nxt = cfg_data[0];
          fill_nxt       = cfg_data[0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vrlm_pkg::S_IDLE;
      mask_width_r <= WIDTH_W'(1);
      first_fill_r <= 1'b0;
      acc_r        <= '0;
      gc_r         <= '0;
      column_r     <= '0;
      row_r        <= '0;
      fill_r       <= 1'b0;
      err_r        <= vrlm_pkg::ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mask_width_r <= mask_width_nxt;
      first_fill_r <= first_fill_nxt;
      acc_r        <= acc_nxt;
      gc_r         <= gc_nxt;
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      fill_r       <= fill_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    run_r      <= run_nxt;
    nx_r       <= nx_nxt;
    col_r      <= col_nxt;
    rbase_r    <= rbase_nxt;
    r0w_r      <= r0w_nxt;
    h_r        <= h_nxt;
    x_r        <= x_nxt;
    run_fill_r <= run_fill_nxt;
    idx_r      <= idx_nxt;
    term_st_r  <= term_st_nxt;
    term_h_r   <= term_h_nxt;
    out_kind_r <= out_kind_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_w_r    <= out_w_nxt;
    out_h_r    <= out_h_nxt;
    out_mh_r   <= out_mh_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_rect_x      = out_x_r;
  assign out_rect_y      = out_y_r;
  assign out_rect_width  = out_w_r;
  assign out_rect_height = out_h_r;
  assign out_mask_height = out_mh_r;
  assign out_status      = out_st_r;
  assign out_last        = out_last_r;

endmodule
